// ----- rtl/dsff_pkg.sv -----
// Shared types and constants for the dual sensor force fusion block.
// No dependencies.
package dsff_pkg;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_COS_A = 2'd0;
    localparam t_cfg_idx CFG_SIN_A = 2'd1;
    localparam t_cfg_idx CFG_COS_B = 2'd2;
    localparam t_cfg_idx CFG_SIN_B = 2'd3;

    localparam int CFG_W  = 16;
    localparam int ANG_W  = 16;
    localparam int MAGT_W = 17;
    localparam int MAGS_W = 16;

    localparam logic signed [CFG_W-1:0] COEF_ONE  = 16'sd16384;
    localparam logic signed [CFG_W-1:0] COEF_ZERO = 16'sd0;

    // atan(2^-i) with a full turn equal to 2^32
    localparam int ATAN_N = 24;
    localparam logic [31:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [MAGT_W-1:0] mag_t;
        logic [ANG_W-1:0]  ang;
        logic [MAGS_W-1:0] mag_a;
        logic [MAGS_W-1:0] mag_b;
    } t_res;

endpackage

// ----- rtl/dsff_mag.sv -----
// Pipelined vector magnitude: squares, sum, one root bit per stage, rounding.
// Depends on nothing but its parameters.
module dsff_mag #(
    parameter int IW    = 24,
    parameter int OW    = 16,
    parameter int DEPTH = 29
) (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic signed [IW-1:0] i_x,
    input  logic signed [IW-1:0] i_y,
    output logic [OW-1:0]        o_mag
);
    localparam int SQ = 2 * IW;
    localparam int W2 = SQ + 1;
    localparam int R  = (W2 + 1) / 2;
    localparam int RW = W2 + 1;
    localparam int M  = DEPTH - 3;

    logic signed [SQ-1:0] r_sqx, r_sqy;
    logic [RW-1:0] r_n [0:M-1];
    logic [RW-1:0] r_r [0:M];
    logic [RW-1:0] w_rnd;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sqx  <= i_x * i_x;
            r_sqy  <= i_y * i_y;
            r_n[0] <= RW'({1'b0, r_sqx}) + RW'({1'b0, r_sqy});
            r_r[0] <= '0;
        end
    end

    for (genvar k = 0; k < M; k++) begin : g_stg
        if (k < R) begin : g_it
            localparam int B = 2 * (R - 1 - k);
            logic [RW-1:0] w_bit, w_t;
            logic          w_ge;
            assign w_bit = RW'(1) << B;
            assign w_t   = r_r[k] + w_bit;
            assign w_ge  = (r_n[k] >= w_t);
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_r[k+1] <= w_ge ? ((r_r[k] >> 1) + w_bit) : (r_r[k] >> 1);
                end
            end
            if (k + 1 < M) begin : g_n
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        r_n[k+1] <= w_ge ? (r_n[k] - w_t) : r_n[k];
                    end
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_r[k+1] <= r_r[k];
                end
            end
            if (k + 1 < M) begin : g_n
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        r_n[k+1] <= r_n[k];
                    end
                end
            end
        end
    end

    // round half up to whole sensor units, then clip to the field
    assign w_rnd = (r_r[M] + RW'(8)) >> 4;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_mag <= (w_rnd > RW'({OW{1'b1}})) ? {OW{1'b1}} : w_rnd[OW-1:0];
        end
    end

endmodule

// ----- rtl/dsff_cordic.sv -----
// Pipelined vectoring CORDIC: angle of the total vector plus heading.
// Depends on dsff_pkg (atan table, angle width).
module dsff_cordic #(
    parameter int IW    = 25,
    parameter int NS    = 16,
    parameter int DEPTH = 29
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic signed [IW-1:0]        i_x,
    input  logic signed [IW-1:0]        i_y,
    input  logic [dsff_pkg::ANG_W-1:0]  i_head,
    output logic [dsff_pkg::ANG_W-1:0]  o_ang
);
    import dsff_pkg::*;

    localparam int XW = IW + 19;
    localparam int M  = DEPTH - 2;

    logic signed [XW-1:0] r_x [0:M-1];
    logic signed [XW-1:0] r_y [0:M-1];
    logic [31:0]          r_z [0:M];
    logic                 r_zf [0:M];
    logic [ANG_W-1:0]     r_h [0:M];
    logic signed [XW-1:0] w_x0, w_y0;
    logic [31:0]          w_zr;

    assign w_x0 = {{(XW-IW-16){i_x[IW-1]}}, i_x, 16'b0};
    assign w_y0 = {{(XW-IW-16){i_y[IW-1]}}, i_y, 16'b0};

    // left half plane: turn by pi first
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zf[0] <= (i_x == '0) && (i_y == '0);
            r_h[0]  <= i_head;
            if (i_x[IW-1]) begin
                r_x[0] <= -w_x0;
                r_y[0] <= -w_y0;
                r_z[0] <= 32'h8000_0000;
            end else begin
                r_x[0] <= w_x0;
                r_y[0] <= w_y0;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < M; k++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_zf[k+1] <= r_zf[k];
                r_h[k+1]  <= r_h[k];
            end
        end
        if (k < NS) begin : g_it
            logic signed [XW-1:0] w_xs, w_ys;
            assign w_xs = r_x[k] >>> k;
            assign w_ys = r_y[k] >>> k;
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_z[k+1] <= r_y[k][XW-1] ? (r_z[k] - ATAN_TAB[k])
                                             : (r_z[k] + ATAN_TAB[k]);
                end
            end
            if (k + 1 < M) begin : g_xy
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        if (r_y[k][XW-1]) begin
                            r_x[k+1] <= r_x[k] - w_ys;
                            r_y[k+1] <= r_y[k] + w_xs;
                        end else begin
                            r_x[k+1] <= r_x[k] + w_ys;
                            r_y[k+1] <= r_y[k] - w_xs;
                        end
                    end
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_z[k+1] <= r_z[k];
                end
            end
            if (k + 1 < M) begin : g_xy
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        r_x[k+1] <= r_x[k];
                        r_y[k+1] <= r_y[k];
                    end
                end
            end
        end
    end

    assign w_zr = r_z[M] + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_ang <= r_zf[M] ? r_h[M] : (w_zr[31:16] + r_h[M]);
        end
    end

endmodule

// ----- rtl/dual_sensor_force_fusion.sv -----
// Top level of the dual sensor force fusion block.
// Depends on dsff_pkg, dsff_mag and dsff_cordic.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one force reading per
//   sensor plus a heading; a transaction happens when both are high.
//   Output channel (o_out_valid / i_out_ready) returns total magnitude,
//   total angle (heading added, wrapped binary angle) and each sensor's
//   magnitude, one result transaction per input transaction, in order.
//   Mounting coefficients are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the block is idle; unknown indexes cannot occur.
// Pipeline: product, sum and total vector stages, then the magnitude and
//   CORDIC units, then the output register; the bit-per-stage square root sets the depth.
// Throughput: one transaction per cycle while the skid entry is empty; every stage is a register.
// Reset: synchronous, active low; clears valid bits and loads unit
//   rotation coefficients (cos = 1.0, sin = 0).
// Stall: a one-entry skid register catches the result leaving the pipe
//   when the receiver stalls; the pipe freezes only while it is full.
module dual_sensor_force_fusion #(
    parameter int CORDIC_STAGES = 16,
    parameter int FORCE_WIDTH   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  dsff_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [dsff_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [FORCE_WIDTH-1:0]    i_force_a_x,
    input  logic signed [FORCE_WIDTH-1:0]    i_force_a_y,
    input  logic signed [FORCE_WIDTH-1:0]    i_force_b_x,
    input  logic signed [FORCE_WIDTH-1:0]    i_force_b_y,
    input  logic signed [dsff_pkg::ANG_W-1:0] i_heading_angle,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dsff_pkg::MAGT_W-1:0]      o_total_magnitude,
    output logic signed [dsff_pkg::ANG_W-1:0] o_total_angle,
    output logic [dsff_pkg::MAGS_W-1:0]      o_magnitude_a,
    output logic [dsff_pkg::MAGS_W-1:0]      o_magnitude_b
);
    import dsff_pkg::*;

    localparam int FW  = FORCE_WIDTH;
    localparam int PW  = FW + 16;   // product width
    localparam int SW  = FW + 18;   // rotation sum width
    localparam int GW  = FW + 8;    // rotated Q4 component
    localparam int TW  = FW + 9;    // total Q4 component
    localparam int NS  = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int LC  = NS + 2;
    localparam int LM  = FW + 13;   // mag unit: 2 + root bits + 1
    localparam int LAT = (LC > LM) ? LC : LM;
    localparam int NV  = 3 + LAT;

    // configuration
    logic signed [CFG_W-1:0] r_cos_a, r_sin_a, r_cos_b, r_sin_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_a <= COEF_ONE;
            r_sin_a <= COEF_ZERO;
            r_cos_b <= COEF_ONE;
            r_sin_b <= COEF_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COS_A: r_cos_a <= i_cfg_data;
                CFG_SIN_A: r_sin_a <= i_cfg_data;
                CFG_COS_B: r_cos_b <= i_cfg_data;
                CFG_SIN_B: r_sin_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advance: frozen only while the skid entry is occupied
    logic r_skid_v;
    logic w_ce;
    assign w_ce       = ~r_skid_v;
    assign o_in_ready = w_ce;

    logic [NV-1:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_ce) begin
            r_v <= {r_v[NV-2:0], i_in_valid};
        end
    end

    // stage 1: products
    logic signed [PW-1:0] r_axc, r_ays, r_axs, r_ayc;
    logic signed [PW-1:0] r_bxc, r_bys, r_bxs, r_byc;
    logic [ANG_W-1:0]     r_h1, r_h2, r_h3;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_axc <= i_force_a_x * r_cos_a;
            r_ays <= i_force_a_y * r_sin_a;
            r_axs <= i_force_a_x * r_sin_a;
            r_ayc <= i_force_a_y * r_cos_a;
            r_bxc <= i_force_b_x * r_cos_b;
            r_bys <= i_force_b_y * r_sin_b;
            r_bxs <= i_force_b_x * r_sin_b;
            r_byc <= i_force_b_y * r_cos_b;
            r_h1  <= i_heading_angle;
        end
    end

    // stage 2: Q14 sums rounded half up to Q4
    logic signed [SW-1:0] w_sax, w_say, w_sbx, w_sby;
    logic signed [GW-1:0] r_agx, r_agy, r_bgx, r_bgy;

    assign w_sax = SW'(r_axc) - SW'(r_ays) + SW'(512);
    assign w_say = SW'(r_axs) + SW'(r_ayc) + SW'(512);
    assign w_sbx = SW'(r_bxc) - SW'(r_bys) + SW'(512);
    assign w_sby = SW'(r_bxs) + SW'(r_byc) + SW'(512);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_agx <= w_sax[SW-1:10];
            r_agy <= w_say[SW-1:10];
            r_bgx <= w_sbx[SW-1:10];
            r_bgy <= w_sby[SW-1:10];
            r_h2  <= r_h1;
        end
    end

    // stage 3: total vector
    logic signed [GW-1:0] r_ax3, r_ay3, r_bx3, r_by3;
    logic signed [TW-1:0] r_tx, r_ty;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_tx  <= TW'(r_agx) + TW'(r_bgx);
            r_ty  <= TW'(r_agy) + TW'(r_bgy);
            r_ax3 <= r_agx;
            r_ay3 <= r_agy;
            r_bx3 <= r_bgx;
            r_by3 <= r_bgy;
            r_h3  <= r_h2;
        end
    end

    t_res w_res;

    dsff_mag #(.IW(TW), .OW(MAGT_W), .DEPTH(LAT)) u_mag_t (
        .i_clk(i_clk), .i_ce(w_ce), .i_x(r_tx), .i_y(r_ty), .o_mag(w_res.mag_t)
    );
    dsff_mag #(.IW(GW), .OW(MAGS_W), .DEPTH(LAT)) u_mag_a (
        .i_clk(i_clk), .i_ce(w_ce), .i_x(r_ax3), .i_y(r_ay3), .o_mag(w_res.mag_a)
    );
    dsff_mag #(.IW(GW), .OW(MAGS_W), .DEPTH(LAT)) u_mag_b (
        .i_clk(i_clk), .i_ce(w_ce), .i_x(r_bx3), .i_y(r_by3), .o_mag(w_res.mag_b)
    );
    dsff_cordic #(.IW(TW), .NS(NS), .DEPTH(LAT)) u_cordic (
        .i_clk(i_clk), .i_ce(w_ce), .i_x(r_tx), .i_y(r_ty), .i_head(r_h3),
        .o_ang(w_res.ang)
    );

    // output register plus skid entry
    logic r_out_v;
    t_res r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (i_out_ready || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_v[NV-1];
            end
        end else if (r_v[NV-1] && w_ce) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_ready || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_ce) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_total_magnitude = r_out.mag_t;
    assign o_total_angle     = r_out.ang;
    assign o_magnitude_a     = r_out.mag_a;
    assign o_magnitude_b     = r_out.mag_b;

endmodule
